// ===== hdl/calendar_catchup_and_season_shift_unit_assert.svh =====
// ----------------------------------------------------------------------------
// calendar_catchup_and_season_shift_unit_assert.svh
// Assertion macros shared by the calendar unit.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CATCHUP_AND_SEASON_SHIFT_UNIT_ASSERT_SVH
`define CALENDAR_CATCHUP_AND_SEASON_SHIFT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CCSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar unit: same-cycle check failed");

// next-cycle implication, checked out of reset
`define CCSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar unit: next-cycle check failed");

`endif

// ===== hdl/ccss_pkg.sv =====
// ----------------------------------------------------------------------------
// ccss_pkg
// Types, constants and calendar helper functions for the calendar unit.
// ----------------------------------------------------------------------------
package ccss_pkg;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_CATCHUP = 2'd1,
        FUNC_SUMMER  = 2'd2,
        FUNC_WINTER  = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REACHED = 2'd1,
        ST_GAVE_UP = 2'd2
    } status_t;

    localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
    localparam logic [3:0] MONTHS_PER_YEAR  = 4'd12;
    localparam logic [4:0] LAST_HOUR        = 5'd23;
    localparam logic [7:0] YEAR_WRAP        = 8'd100;
    localparam logic [6:0] YEAR_LAST        = 7'd99;
    localparam logic [8:0] COUNT_MAX        = 9'd511;
    localparam logic [7:0] MAX_DAYS_RESET   = 8'd10;

    // register map (index within the APB window)
    localparam logic REG_MAX_DAYS_OFF = 1'b0;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } cal_t;

    typedef struct packed {
        cal_t       cal;
        logic [1:0] status;
    } res_t;

    // days in a month; months outside 1..12 count as 31, leap when year%4==0
    function automatic logic [4:0] days_in(input logic [3:0] month,
                                           input logic [6:0] year);
        logic [4:0] d;
        case (month)
            4'd2:                      d = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // year count-up with wrap at 100 (anything 99 or more goes to 0)
    function automatic logic [6:0] year_up(input logic [6:0] year);
        logic [7:0] y1;
        y1 = {1'b0, year} + 8'd1;
        return (y1 >= YEAR_WRAP) ? 7'd0 : y1[6:0];
    endfunction

    // day advance with month and year carries
    function automatic cal_t day_up(input cal_t c);
        cal_t       r;
        logic [4:0] d1;
        logic [3:0] m1;
        r  = c;
        d1 = c.day + 5'd1;
        m1 = c.month + 4'd1;
        if (d1 > days_in(c.month, c.year))
        begin
            r.day = 5'd1;
            if (m1 > MONTHS_PER_YEAR)
            begin
                r.month = 4'd1;
                r.year  = year_up(c.year);
            end
            else
            begin
                r.month = m1;
            end
        end
        else
        begin
            r.day = d1;
        end
        return r;
    endfunction

endpackage

// ===== hdl/ccss_if.sv =====
// ----------------------------------------------------------------------------
// ccss_if
// Valid/ready channels for the calendar unit: item in, result out.
// ----------------------------------------------------------------------------
interface ccss_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [5:0] in_minute;
    logic [4:0] in_hour;
    logic [4:0] in_day;
    logic [3:0] in_month;
    logic [6:0] in_year;

    modport source (output valid, func, in_minute, in_hour, in_day, in_month, in_year,
                    input ready);
    modport sink   (input valid, func, in_minute, in_hour, in_day, in_month, in_year,
                    output ready);
endinterface

interface ccss_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] out_minute;
    logic [4:0] out_hour;
    logic [4:0] out_day;
    logic [3:0] out_month;
    logic [6:0] out_year;
    logic [1:0] status;

    modport source (output valid, out_minute, out_hour, out_day, out_month, out_year,
                    status, input ready);
    modport sink   (input valid, out_minute, out_hour, out_day, out_month, out_year,
                    status, output ready);
endinterface

// ===== hdl/calendar_catchup_and_season_shift_unit.sv =====
// Throughput: one item per cycle while the skid is empty; results go to the result
// register, or to the skid while one waits. Between the calendar and result registers
// the step is a single pass of compare, carry chain and days-in-month lookup.
// A two-deep output stage (result + skid) keeps input open while one result waits.
// Reset (rst_n, async, active low): calendar 00:00 day 1 month 1 year 0, day count 0,
// max_days_off 10, output empty.
// ----------------------------------------------------------------------------
// calendar_catchup_and_season_shift_unit
// Calendar clock with catch-up stepping, day limit and summer/winter shift.
// ----------------------------------------------------------------------------
`include "calendar_catchup_and_season_shift_unit_assert.svh"

module calendar_catchup_and_season_shift_unit (
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // item channels
    ccss_in_if.sink           in_word,
    ccss_out_if.source        out_word
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [7:0] max_days_off_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ccss_pkg::REG_MAX_DAYS_OFF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_days_off_reg <= ccss_pkg::MAX_DAYS_RESET;
        else if (cfg_wr)
            max_days_off_reg <= pwdata[7:0];
    end

    // read back (low address bits select nothing)
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == ccss_pkg::REG_MAX_DAYS_OFF)
            prdata = {24'd0, max_days_off_reg};
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    ccss_pkg::res_t out_reg, out_next;
    ccss_pkg::res_t skid_reg, skid_next;

    assign in_word.ready = !skid_valid_reg;
    assign in_acc        = in_word.valid && in_word.ready;

    // ------------------------------------------------------------------
    // calendar step
    // ------------------------------------------------------------------
    ccss_pkg::cal_t cal_reg, cal_next;
    logic [8:0]     days_reg, days_next;
    ccss_pkg::cal_t tgt;
    ccss_pkg::res_t res;

    assign tgt.minute = in_word.in_minute;
    assign tgt.hour   = in_word.in_hour;
    assign tgt.day    = in_word.in_day;
    assign tgt.month  = in_word.in_month;
    assign tgt.year   = in_word.in_year;

    always_comb
    begin
        logic [5:0]       min1;
        logic [4:0]       hr1;
        logic [8:0]       cnt1;
        logic [1:0]       st;
        ccss_pkg::cal_t   c;
        c    = cal_reg;
        st   = ccss_pkg::ST_DONE;
        days_next = days_reg;
        min1 = cal_reg.minute + 6'd1;
        hr1  = cal_reg.hour + 5'd1;
        cnt1 = (days_reg < ccss_pkg::COUNT_MAX) ? days_reg + 9'd1 : days_reg;
        case (ccss_pkg::func_t'(in_word.func))
            ccss_pkg::FUNC_LOAD:
            begin
                c         = tgt;
                days_next = 9'd0;
            end
            ccss_pkg::FUNC_CATCHUP:
            begin
                if (cal_reg == tgt)
                begin
                    st = ccss_pkg::ST_REACHED;
                end
                else if (min1 >= ccss_pkg::MINUTES_PER_HOUR)
                begin
                    c.minute = 6'd0;
                    if (hr1 >= ccss_pkg::HOURS_PER_DAY)
                    begin
                        // hour wrap: count the day, check the limit
                        c.hour    = 5'd0;
                        days_next = cnt1;
                        if (cnt1 > {1'b0, max_days_off_reg})
                            st = ccss_pkg::ST_GAVE_UP;
                        else
                            c = ccss_pkg::day_up(c);
                    end
                    else
                    begin
                        c.hour = hr1;
                    end
                end
                else
                begin
                    c.minute = min1;
                end
            end
            ccss_pkg::FUNC_SUMMER:
            begin
                if (hr1 >= ccss_pkg::HOURS_PER_DAY)
                begin
                    c.hour = 5'd0;
                    c      = ccss_pkg::day_up(c);
                end
                else
                begin
                    c.hour = hr1;
                end
            end
            ccss_pkg::FUNC_WINTER:
            begin
                if (cal_reg.hour != 5'd0)
                begin
                    c.hour = cal_reg.hour - 5'd1;
                end
                else
                begin
                    c.hour = ccss_pkg::LAST_HOUR;
                    if (cal_reg.day > 5'd1)
                    begin
                        c.day = cal_reg.day - 5'd1;
                    end
                    else
                    begin
                        // step back into previous month, land on its last day
                        if (cal_reg.month > 4'd1)
                        begin
                            c.month = cal_reg.month - 4'd1;
                        end
                        else
                        begin
                            c.month = ccss_pkg::MONTHS_PER_YEAR;
                            c.year  = (cal_reg.year == 7'd0) ? ccss_pkg::YEAR_LAST
                                                             : cal_reg.year - 7'd1;
                        end
                        c.day = ccss_pkg::days_in(c.month, c.year);
                    end
                end
            end
            default:
            begin
                c = cal_reg;
            end
        endcase
        cal_next   = c;
        res.cal    = c;
        res.status = st;
    end

    // calendar state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.minute <= 6'd0;
            cal_reg.hour   <= 5'd0;
            cal_reg.day    <= 5'd1;
            cal_reg.month  <= 4'd1;
            cal_reg.year   <= 7'd0;
            days_reg       <= 9'd0;
        end
        else if (in_acc)
        begin
            cal_reg  <= cal_next;
            days_reg <= days_next;
        end
    end

    // ------------------------------------------------------------------
    // output stage: result register plus skid
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_word.ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload words, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_word.valid      = out_valid_reg;
    assign out_word.out_minute = out_reg.cal.minute;
    assign out_word.out_hour   = out_reg.cal.hour;
    assign out_word.out_day    = out_reg.cal.day;
    assign out_word.out_month  = out_reg.cal.month;
    assign out_word.out_year   = out_reg.cal.year;
    assign out_word.status     = out_reg.status;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // skid only ever holds a word behind a held result word
    `CCSS_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // a load sets the calendar to the loaded minute and clears the day count
    `CCSS_ASSERT_NXT(a_load_sets, clk, rst_n, in_acc && (in_word.func == ccss_pkg::FUNC_LOAD), (cal_reg.minute == $past(in_word.in_minute)) && (days_reg == 9'd0))
    // season shifts never touch the day count
    `CCSS_ASSERT_NXT(a_shift_keeps_count, clk, rst_n, in_acc && (in_word.func == ccss_pkg::FUNC_SUMMER || in_word.func == ccss_pkg::FUNC_WINTER), $stable(days_reg))

endmodule
